/* hdl/pfpc_pkg.sv */
// ----------------------------------------------------------------------------
// pfpc_pkg
// Shared types and constants for the pixel format pack/unpack pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pfpc_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned BppW     = 6;
  localparam int unsigned MaskW    = 6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BPP   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FLAGS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PAL   = 2'd2;

  localparam logic [BppW-1:0] BPP_RESET  = 6'd32;
  localparam logic [BppW-1:0] BPP_FOUR   = 6'd32;
  localparam logic [BppW-1:0] BPP_SIXTEEN = 6'd16;
  localparam logic [7:0]      FLAGS_RESET = 8'h01;

  // configuration flag bit positions
  localparam int unsigned FlagRgb   = 0;
  localparam int unsigned FlagHalf  = 1;
  localparam int unsigned FlagTile  = 6;
  localparam int unsigned FlagAonly = 7;

  // direction of a request
  localparam logic OP_UNPACK = 1'b0;
  localparam logic OP_PACK   = 1'b1;

  // write masks per layout
  localparam logic [MaskW-1:0] MASK_FOUR    = 6'h0F;
  localparam logic [MaskW-1:0] MASK_TILE    = 6'h33;
  localparam logic [MaskW-1:0] MASK_SIXTEEN = 6'h03;
  localparam logic [MaskW-1:0] MASK_AONLY   = 6'h01;
  localparam logic [MaskW-1:0] MASK_RGB24   = 6'h07;
  localparam logic [MaskW-1:0] MASK_NONE    = 6'h00;

  typedef enum logic [3:0] {
    LAY_FOUR    = 4'b0001,
    LAY_SIXTEEN = 4'b0010,
    LAY_AONLY   = 4'b0100,
    LAY_RGB24   = 4'b1000
  } layout_e;

  typedef struct packed {
    logic    op;
    layout_e layout;
    logic    rgb;
    logic    half;
    logic    tile;
  } ctrl_t;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] far0;
    logic [7:0] far1;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic [7:0]       ob0;
    logic [7:0]       ob1;
    logic [7:0]       ob2;
    logic [7:0]       ob3;
    logic [7:0]       far0;
    logic [7:0]       far1;
    logic [MaskW-1:0] mask;
  } res_t;

endpackage

`default_nettype wire

/* hdl/pixel_format_pack_unpack.sv */
// ----------------------------------------------------------------------------
// pixel_format_pack_unpack
// Converts one pixel between stored bytes and 8-bit RGBA, per configured
// layout.
//
//   channel   ports                             handshake
//   -------   -------------------------------   ---------------------------
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i  write when cfg_we_i high
//   request   op_i, in_*_i, *_in_i               start_i high, busy_o low
//   result    *_out_o, out_*_o, write_mask_o     done_o high for one cycle
//
// Three register stages (decode, route, alpha scale) lie between a taken request
// and its result. One request per cycle, busy_o stays low.
// Reset sets the registers to depth 32, RGB order, no palette and empties
// the pipeline. The receiver cannot stall, so nothing is ever held back.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_format_pack_unpack (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [pfpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [pfpc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          op_i,
  input  wire logic [7:0]                    in_byte0_i,
  input  wire logic [7:0]                    in_byte1_i,
  input  wire logic [7:0]                    in_byte2_i,
  input  wire logic [7:0]                    in_byte3_i,
  input  wire logic [7:0]                    in_far0_i,
  input  wire logic [7:0]                    in_far1_i,
  input  wire logic [7:0]                    red_in_i,
  input  wire logic [7:0]                    green_in_i,
  input  wire logic [7:0]                    blue_in_i,
  input  wire logic [7:0]                    alpha_in_i,
  output logic                               done_o,
  output logic [7:0]                         red_out_o,
  output logic [7:0]                         green_out_o,
  output logic [7:0]                         blue_out_o,
  output logic [7:0]                         alpha_out_o,
  output logic [7:0]                         out_byte0_o,
  output logic [7:0]                         out_byte1_o,
  output logic [7:0]                         out_byte2_o,
  output logic [7:0]                         out_byte3_o,
  output logic [7:0]                         out_far0_o,
  output logic [7:0]                         out_far1_o,
  output logic [pfpc_pkg::MaskW-1:0]         write_mask_o
);

  pfpc_pkg::pix_t  pix_in;
  pfpc_pkg::pix_t  pix_s1;
  pfpc_pkg::ctrl_t ctrl_s1;
  pfpc_pkg::res_t  res_s2;
  pfpc_pkg::res_t  res_s3;
  logic            accept;
  logic            valid_s1;
  logic            valid_s2;
  logic            expand_s2;
  logic            valid_s3;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    pix_in.byte0 = in_byte0_i;
    pix_in.byte1 = in_byte1_i;
    pix_in.byte2 = in_byte2_i;
    pix_in.byte3 = in_byte3_i;
    pix_in.far0  = in_far0_i;
    pix_in.far1  = in_far1_i;
    pix_in.red   = red_in_i;
    pix_in.green = green_in_i;
    pix_in.blue  = blue_in_i;
    pix_in.alpha = alpha_in_i;
  end

  pfpc_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (accept),
    .op_i        (op_i),
    .pix_i       (pix_in),
    .valid_o     (valid_s1),
    .ctrl_o      (ctrl_s1),
    .pix_o       (pix_s1)
  );

  pfpc_convert u_convert (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_s1),
    .ctrl_i   (ctrl_s1),
    .pix_i    (pix_s1),
    .valid_o  (valid_s2),
    .expand_o (expand_s2),
    .res_o    (res_s2)
  );

  pfpc_finish u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_s2),
    .expand_i (expand_s2),
    .res_i    (res_s2),
    .valid_o  (valid_s3),
    .res_o    (res_s3)
  );

  assign done_o       = valid_s3;
  assign red_out_o    = res_s3.red;
  assign green_out_o  = res_s3.green;
  assign blue_out_o   = res_s3.blue;
  assign alpha_out_o  = res_s3.alpha;
  assign out_byte0_o  = res_s3.ob0;
  assign out_byte1_o  = res_s3.ob1;
  assign out_byte2_o  = res_s3.ob2;
  assign out_byte3_o  = res_s3.ob3;
  assign out_far0_o   = res_s3.far0;
  assign out_far1_o   = res_s3.far1;
  assign write_mask_o = res_s3.mask;

endmodule

`default_nettype wire

/* hdl/pfpc_decode.sv */
// ----------------------------------------------------------------------------
// pfpc_decode
// Configuration registers and first stage: layout decode and input capture.
// ----------------------------------------------------------------------------
`default_nettype none

module pfpc_decode (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pfpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [pfpc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                           valid_i,
  input  wire logic                           op_i,
  input  wire pfpc_pkg::pix_t                 pix_i,
  output logic                                valid_o,
  output pfpc_pkg::ctrl_t                     ctrl_o,
  output pfpc_pkg::pix_t                      pix_o
);

  logic [pfpc_pkg::BppW-1:0] bpp_q;
  logic [7:0]                flags_q;
  logic                      pal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= pfpc_pkg::BPP_RESET;
      flags_q <= pfpc_pkg::FLAGS_RESET;
      pal_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfpc_pkg::CFG_BPP:   bpp_q   <= cfg_wdata_i[pfpc_pkg::BppW-1:0];
        pfpc_pkg::CFG_FLAGS: flags_q <= cfg_wdata_i;
        pfpc_pkg::CFG_PAL:   pal_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  pfpc_pkg::ctrl_t ctrl_d;

  always_comb begin
    ctrl_d.op   = op_i;
    ctrl_d.rgb  = flags_q[pfpc_pkg::FlagRgb];
    ctrl_d.half = flags_q[pfpc_pkg::FlagHalf];
    ctrl_d.tile = flags_q[pfpc_pkg::FlagTile];
    priority if (bpp_q == pfpc_pkg::BPP_FOUR || pal_q) begin
      ctrl_d.layout = pfpc_pkg::LAY_FOUR;
    end else if (bpp_q == pfpc_pkg::BPP_SIXTEEN) begin
      ctrl_d.layout = pfpc_pkg::LAY_SIXTEEN;
    end else if (flags_q[pfpc_pkg::FlagAonly] && flags_q[pfpc_pkg::FlagTile]) begin
      ctrl_d.layout = pfpc_pkg::LAY_AONLY;
    end else begin
      ctrl_d.layout = pfpc_pkg::LAY_RGB24;
    end
  end

  logic            valid_q;
  pfpc_pkg::ctrl_t ctrl_q;
  pfpc_pkg::pix_t  pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      ctrl_q <= ctrl_d;
      pix_q  <= pix_i;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign pix_o   = pix_q;

endmodule

`default_nettype wire

/* hdl/pfpc_convert.sv */
// ----------------------------------------------------------------------------
// pfpc_convert
// Second stage: channel and byte routing for the selected layout.
// ----------------------------------------------------------------------------
`default_nettype none

module pfpc_convert (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire pfpc_pkg::ctrl_t ctrl_i,
  input  wire pfpc_pkg::pix_t  pix_i,
  output logic                 valid_o,
  output logic                 expand_o,
  output pfpc_pkg::res_t       res_o
);

  pfpc_pkg::res_t res_d;
  logic           expand_d;
  logic [8:0]     half_sum;
  logic [7:0]     pa;
  logic [7:0]     hic;
  logic [7:0]     loc;
  logic [15:0]    word;

  always_comb begin
    half_sum = {1'b0, pix_i.alpha} + 9'd1;
    pa       = ctrl_i.half ? half_sum[8:1] : pix_i.alpha;
    hic      = ctrl_i.rgb ? pix_i.blue : pix_i.red;
    loc      = ctrl_i.rgb ? pix_i.red : pix_i.blue;
    word     = {pix_i.byte1, pix_i.byte0};
    res_d    = '0;
    expand_d = 1'b0;
    if (ctrl_i.op == pfpc_pkg::OP_UNPACK) begin
      unique case (ctrl_i.layout)
        pfpc_pkg::LAY_FOUR: begin
          expand_d = ctrl_i.half;
          priority if (ctrl_i.rgb) begin
            res_d.red   = pix_i.byte0;
            res_d.green = pix_i.byte1;
            res_d.blue  = pix_i.byte2;
            res_d.alpha = pix_i.byte3;
          end else if (ctrl_i.tile) begin
            res_d.alpha = pix_i.byte0;
            res_d.red   = pix_i.byte1;
            res_d.green = pix_i.far0;
            res_d.blue  = pix_i.far1;
          end else begin
            res_d.blue  = pix_i.byte0;
            res_d.green = pix_i.byte1;
            res_d.red   = pix_i.byte2;
            res_d.alpha = pix_i.byte3;
          end
        end
        pfpc_pkg::LAY_SIXTEEN: begin
          res_d.alpha = {8{word[15]}};
          res_d.green = {word[9:5], 3'b000};
          if (ctrl_i.rgb) begin
            res_d.blue = {word[14:10], 3'b000};
            res_d.red  = {word[4:0], 3'b000};
          end else begin
            res_d.red  = {word[14:10], 3'b000};
            res_d.blue = {word[4:0], 3'b000};
          end
        end
        pfpc_pkg::LAY_AONLY: begin
          res_d.red   = 8'hFF;
          res_d.green = 8'hFF;
          res_d.blue  = 8'hFF;
          res_d.alpha = pix_i.byte0;
        end
        default: begin
          res_d.alpha = 8'hFF;
          res_d.green = pix_i.byte1;
          if (ctrl_i.rgb) begin
            res_d.red  = pix_i.byte0;
            res_d.blue = pix_i.byte2;
          end else begin
            res_d.blue = pix_i.byte0;
            res_d.red  = pix_i.byte2;
          end
        end
      endcase
    end else begin
      unique case (ctrl_i.layout)
        pfpc_pkg::LAY_FOUR: begin
          priority if (ctrl_i.rgb) begin
            res_d.ob0  = pix_i.red;
            res_d.ob1  = pix_i.green;
            res_d.ob2  = pix_i.blue;
            res_d.ob3  = pa;
            res_d.mask = pfpc_pkg::MASK_FOUR;
          end else if (ctrl_i.tile) begin
            res_d.ob0  = pa;
            res_d.ob1  = pix_i.red;
            res_d.far0 = pix_i.green;
            res_d.far1 = pix_i.blue;
            res_d.mask = pfpc_pkg::MASK_TILE;
          end else begin
            res_d.ob0  = pix_i.blue;
            res_d.ob1  = pix_i.green;
            res_d.ob2  = pix_i.red;
            res_d.ob3  = pa;
            res_d.mask = pfpc_pkg::MASK_FOUR;
          end
        end
        pfpc_pkg::LAY_SIXTEEN: begin
          // 1-5-5-5 word, low byte first
          res_d.ob0  = {pix_i.green[5:3], loc[7:3]};
          res_d.ob1  = {pix_i.alpha[7], hic[7:3], pix_i.green[7:6]};
          res_d.mask = pfpc_pkg::MASK_SIXTEEN;
        end
        pfpc_pkg::LAY_AONLY: begin
          res_d.ob0  = pix_i.alpha;
          res_d.mask = pfpc_pkg::MASK_AONLY;
        end
        default: begin
          res_d.ob1  = pix_i.green;
          res_d.ob0  = ctrl_i.rgb ? pix_i.red : pix_i.blue;
          res_d.ob2  = ctrl_i.rgb ? pix_i.blue : pix_i.red;
          res_d.mask = pfpc_pkg::MASK_RGB24;
        end
      endcase
    end
  end

  logic           valid_q;
  logic           expand_q;
  pfpc_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      expand_q <= expand_d;
      res_q    <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign expand_o = expand_q;
  assign res_o    = res_q;

endmodule

`default_nettype wire

/* hdl/pfpc_finish.sv */
// ----------------------------------------------------------------------------
// pfpc_finish
// Third stage: halved alpha expansion and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfpc_finish (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire logic           expand_i,
  input  wire pfpc_pkg::res_t res_i,
  output logic                valid_o,
  output pfpc_pkg::res_t      res_o
);

  pfpc_pkg::res_t res_d;
  logic [15:0]    scaled;

  // a*255 = (a<<8) - a, then >>7 and keep the low byte
  always_comb begin
    scaled = {res_i.alpha, 8'h00} - {8'h00, res_i.alpha};
    res_d  = res_i;
    if (expand_i) begin
      res_d.alpha = scaled[14:7];
    end
  end

  logic           valid_q;
  pfpc_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

/* hdl/pfpc_checker.sv */
// ----------------------------------------------------------------------------
// pfpc_checker
// Port-level checks on the pixel format pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfpc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start_i,
  input wire logic                          busy_o,
  input wire logic                          op_i,
  input wire logic                          done_o,
  input wire logic [7:0]                    red_out_o,
  input wire logic [7:0]                    green_out_o,
  input wire logic [7:0]                    blue_out_o,
  input wire logic [7:0]                    alpha_out_o,
  input wire logic [7:0]                    out_byte0_o,
  input wire logic [7:0]                    out_far0_o,
  input wire logic [pfpc_pkg::MaskW-1:0]    write_mask_o
);

  // every request yields exactly one result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, 3) |-> (done_o == $past(start_i && !busy_o, 3)))
    else $error("result strobe does not follow request by three cycles");

  // on pack the mask is one of the layout masks, so it is empty only for unpack
  a_mask_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(rst_ni, 3) && $past(op_i, 3) == pfpc_pkg::OP_PACK) |->
      (write_mask_o == pfpc_pkg::MASK_FOUR || write_mask_o == pfpc_pkg::MASK_TILE ||
       write_mask_o == pfpc_pkg::MASK_SIXTEEN || write_mask_o == pfpc_pkg::MASK_AONLY ||
       write_mask_o == pfpc_pkg::MASK_RGB24))
    else $error("pack request with an illegal write mask");

  // unpack writes no bytes
  a_unpack_no_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(rst_ni, 3) && $past(op_i, 3) == pfpc_pkg::OP_UNPACK) |->
      (write_mask_o == pfpc_pkg::MASK_NONE && out_byte0_o == 8'h00 && out_far0_o == 8'h00))
    else $error("unpack request drove packed bytes");

  // pack leaves the channel outputs at zero
  a_pack_no_channels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && write_mask_o != pfpc_pkg::MASK_NONE) |->
      (red_out_o == 8'h00 && green_out_o == 8'h00 &&
       blue_out_o == 8'h00 && alpha_out_o == 8'h00))
    else $error("pack request drove channel outputs");

endmodule

bind pixel_format_pack_unpack pfpc_checker u_pfpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .op_i         (op_i),
  .done_o       (done_o),
  .red_out_o    (red_out_o),
  .green_out_o  (green_out_o),
  .blue_out_o   (blue_out_o),
  .alpha_out_o  (alpha_out_o),
  .out_byte0_o  (out_byte0_o),
  .out_far0_o   (out_far0_o),
  .write_mask_o (write_mask_o)
);

`default_nettype wire
